### hw/rtl/roundabout_track_sequencer_assert.svh
// Assertion macros for the roundabout track sequencer checker.
`ifndef ROUNDABOUT_TRACK_SEQUENCER_ASSERT_SVH
`define ROUNDABOUT_TRACK_SEQUENCER_ASSERT_SVH

// Clocked property, quiet while reset is asserted.
`define RTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must hold on every cycle with a result beat on offer.
`define RTS_ASSERT_ON_OUT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (cond)) \
		else $error(msg);

`endif

### hw/rtl/rts_pkg.sv
// Shared types, constants and helper functions of the roundabout track sequencer.
`default_nettype none

package rts_pkg;

	// Field widths
	localparam int POINT_BITS   = 8;
	localparam int ODO_BITS     = 32;
	localparam int THR_BITS     = 8;
	localparam int ARC_BITS     = 32;
	localparam int CNT_BITS     = 8;
	localparam int CODE_BITS    = 4;
	localparam int TRIM_BITS    = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DAT_BITS = 32;
	// wide enough for any point count against any threshold
	localparam int CMP_BITS     = 17;
	// wide enough for travel against the arc length
	localparam int ARC_CMP_BITS = 65;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_LOST_LINE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOUND_LINE  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INSIDE_LOST = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_CORNER = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ARC_TICKS   = 3'd4;

	// Register reset values
	localparam logic [THR_BITS-1:0] LOST_LINE_RST   = 8'd10;
	localparam logic [THR_BITS-1:0] FOUND_LINE_RST  = 8'd50;
	localparam logic [THR_BITS-1:0] INSIDE_LOST_RST = 8'd5;
	localparam logic [THR_BITS-1:0] EXIT_CORNER_RST = 8'd20;
	localparam logic [ARC_BITS-1:0] ARC_TICKS_RST   = 32'd10000;

	// Debounce limits
	localparam logic [CNT_BITS-1:0] BEGIN_MISS_MIN  = 8'd2;
	localparam logic [CNT_BITS-1:0] BEGIN_FOUND_MIN = 8'd1;
	localparam logic [CNT_BITS-1:0] LEND_MISS_MIN   = 8'd3;
	localparam logic [CNT_BITS-1:0] REND_MISS_MIN   = 8'd2;
	localparam logic [CNT_BITS-1:0] CNT_MAX         = 8'd255;

	// Reported state codes
	localparam logic [CODE_BITS-1:0] CODE_NONE   = 4'd0;
	localparam logic [CODE_BITS-1:0] CODE_LBEGIN = 4'd1;
	localparam logic [CODE_BITS-1:0] CODE_RBEGIN = 4'd2;
	localparam logic [CODE_BITS-1:0] CODE_LRUN   = 4'd3;
	localparam logic [CODE_BITS-1:0] CODE_RRUN   = 4'd4;
	localparam logic [CODE_BITS-1:0] CODE_LIN    = 4'd5;
	localparam logic [CODE_BITS-1:0] CODE_RIN    = 4'd6;
	localparam logic [CODE_BITS-1:0] CODE_LOUT   = 4'd7;
	localparam logic [CODE_BITS-1:0] CODE_ROUT   = 4'd8;
	localparam logic [CODE_BITS-1:0] CODE_LEND   = 4'd9;
	localparam logic [CODE_BITS-1:0] CODE_REND   = 4'd10;

	// Sequence phase, one-hot
	typedef enum logic [10:0] {
		PH_NONE   = 11'b000_0000_0001,
		PH_LBEGIN = 11'b000_0000_0010,
		PH_RBEGIN = 11'b000_0000_0100,
		PH_LRUN   = 11'b000_0000_1000,
		PH_RRUN   = 11'b000_0001_0000,
		PH_LIN    = 11'b000_0010_0000,
		PH_RIN    = 11'b000_0100_0000,
		PH_LOUT   = 11'b000_1000_0000,
		PH_ROUT   = 11'b001_0000_0000,
		PH_LEND   = 11'b010_0000_0000,
		PH_REND   = 11'b100_0000_0000
	} rts_phase_t;

	// Configuration registers
	typedef struct packed {
		logic [THR_BITS-1:0] lost_line;
		logic [THR_BITS-1:0] found_line;
		logic [THR_BITS-1:0] inside_lost;
		logic [THR_BITS-1:0] exit_corner;
		logic [ARC_BITS-1:0] arc_ticks;
	} rts_cfg_t;

	// One frame's input beat
	typedef struct packed {
		logic                  left_corner_found;
		logic                  right_corner_found;
		logic                  left_straight;
		logic                  right_straight;
		logic [POINT_BITS-1:0] left_points;
		logic [POINT_BITS-1:0] right_points;
		logic [POINT_BITS-1:0] left_corner_index;
		logic [POINT_BITS-1:0] right_corner_index;
		logic [ODO_BITS-1:0]   odometer;
	} rts_item_t;

	// One frame's result beat
	typedef struct packed {
		logic [CODE_BITS-1:0] ring_state;
		logic                 follow_right;
		logic                 follow_valid;
		logic                 trim_left;
		logic                 trim_right;
		logic [TRIM_BITS-1:0] trim_length;
	} rts_result_t;

	// Counter step that sticks at full scale
	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

	// Point count below a threshold
	function automatic logic pts_lt(input logic [POINT_BITS-1:0] p,
			input logic [THR_BITS-1:0] t);
		return CMP_BITS'(p) < CMP_BITS'(t);
	endfunction

	// Point count above a threshold
	function automatic logic pts_gt(input logic [POINT_BITS-1:0] p,
			input logic [THR_BITS-1:0] t);
		return CMP_BITS'(p) > CMP_BITS'(t);
	endfunction

	// One-hot phase to its reported code
	function automatic logic [CODE_BITS-1:0] phase_code(input rts_phase_t ph);
		logic [CODE_BITS-1:0] c;
		unique case (ph)
			PH_NONE:   c = CODE_NONE;
			PH_LBEGIN: c = CODE_LBEGIN;
			PH_RBEGIN: c = CODE_RBEGIN;
			PH_LRUN:   c = CODE_LRUN;
			PH_RRUN:   c = CODE_RRUN;
			PH_LIN:    c = CODE_LIN;
			PH_RIN:    c = CODE_RIN;
			PH_LOUT:   c = CODE_LOUT;
			PH_ROUT:   c = CODE_ROUT;
			PH_LEND:   c = CODE_LEND;
			PH_REND:   c = CODE_REND;
			default:   c = CODE_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rts_cfg_regs.sv
// Configuration register file of the roundabout track sequencer.
`default_nettype none

module rts_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [rts_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  logic [rts_pkg::CFG_DAT_BITS-1:0] wr_data,
	output rts_pkg::rts_cfg_t                cfg
);
	import rts_pkg::*;

	rts_cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lost_line   <= LOST_LINE_RST;
			cfg_q.found_line  <= FOUND_LINE_RST;
			cfg_q.inside_lost <= INSIDE_LOST_RST;
			cfg_q.exit_corner <= EXIT_CORNER_RST;
			cfg_q.arc_ticks   <= ARC_TICKS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LOST_LINE:   cfg_q.lost_line   <= wr_data[THR_BITS-1:0];
				REG_FOUND_LINE:  cfg_q.found_line  <= wr_data[THR_BITS-1:0];
				REG_INSIDE_LOST: cfg_q.inside_lost <= wr_data[THR_BITS-1:0];
				REG_EXIT_CORNER: cfg_q.exit_corner <= wr_data[THR_BITS-1:0];
				REG_ARC_TICKS:   cfg_q.arc_ticks   <= wr_data[ARC_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/rts_seq.sv
// Roundabout phase sequencer: state registers and the per-frame step logic.
`default_nettype none

module rts_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  rts_pkg::rts_item_t   item,
	input  rts_pkg::rts_cfg_t    cfg,
	output rts_pkg::rts_result_t res
);
	import rts_pkg::*;

	rts_phase_t            phase_q, ph_eff, phase_d;
	logic [CNT_BITS-1:0]   lmiss_q, lfound_q, rmiss_q, rfound_q;
	logic [CNT_BITS-1:0]   lmiss_d, lfound_d, rmiss_d, rfound_d;
	logic [CNT_BITS-1:0]   lmiss_inc, lfound_inc, rmiss_inc, rfound_inc;
	logic [ODO_BITS-1:0]   mark_q, mark_d;
	logic [ODO_BITS-1:0]   travel;
	logic                  arc_done;
	logic                  fr, fv, tl, tr;
	logic [TRIM_BITS-1:0]  tlen;

	// Travel since entry, read as signed; backward travel never finishes
	assign travel   = item.odometer - mark_q;
	assign arc_done = !travel[ODO_BITS-1] &&
		(ARC_CMP_BITS'(travel) >= ARC_CMP_BITS'(cfg.arc_ticks));

	// Miss counts step first, found counts use the stepped miss count
	assign lmiss_inc  = pts_lt(item.left_points, cfg.lost_line)  ? sat_inc(lmiss_q) : lmiss_q;
	assign rmiss_inc  = pts_lt(item.right_points, cfg.lost_line) ? sat_inc(rmiss_q) : rmiss_q;
	assign lfound_inc = sat_inc(lfound_q);
	assign rfound_inc = sat_inc(rfound_q);

	// Entry check ahead of the sequence step
	always_comb begin
		ph_eff = phase_q;
		if (phase_q == PH_NONE) begin
			if (item.left_corner_found && !item.right_corner_found && item.right_straight)
				ph_eff = PH_LBEGIN;
			else if (!item.left_corner_found && item.right_corner_found && item.left_straight)
				ph_eff = PH_RBEGIN;
		end
	end

	// Sequence step
	always_comb begin
		phase_d  = ph_eff;
		lmiss_d  = lmiss_q;
		lfound_d = lfound_q;
		rmiss_d  = rmiss_q;
		rfound_d = rfound_q;
		mark_d   = mark_q;
		fr       = 1'b0;
		fv       = 1'b1;
		tl       = 1'b0;
		tr       = 1'b0;
		tlen     = '0;
		unique case (ph_eff)
			PH_LBEGIN: begin
				fr      = 1'b1;
				lmiss_d = lmiss_inc;
				if (pts_gt(item.left_points, cfg.found_line) && lmiss_inc > BEGIN_MISS_MIN) begin
					lfound_d = lfound_inc;
					if (lfound_inc > BEGIN_FOUND_MIN) begin
						phase_d  = PH_LIN;
						lmiss_d  = '0;
						lfound_d = '0;
						mark_d   = item.odometer;
					end
				end
			end
			PH_LIN: begin
				if (pts_lt(item.left_points, cfg.inside_lost) || arc_done)
					phase_d = PH_LRUN;
			end
			PH_LRUN: begin
				fr = 1'b1;
				if (item.right_corner_found) begin
					tr   = 1'b1;
					tlen = TRIM_BITS'(item.right_corner_index);
					if (pts_lt(item.right_corner_index, cfg.exit_corner))
						phase_d = PH_LOUT;
				end
			end
			PH_LOUT: begin
				if (item.right_straight)
					phase_d = PH_LEND;
			end
			PH_LEND: begin
				fr      = 1'b1;
				lmiss_d = lmiss_inc;
				if (pts_gt(item.left_points, cfg.found_line) && lmiss_inc > LEND_MISS_MIN) begin
					phase_d = PH_NONE;
					lmiss_d = '0;
				end
			end
			PH_RBEGIN: begin
				rmiss_d = rmiss_inc;
				if (pts_gt(item.right_points, cfg.found_line) && rmiss_inc > BEGIN_MISS_MIN) begin
					rfound_d = rfound_inc;
					if (rfound_inc > BEGIN_FOUND_MIN) begin
						phase_d  = PH_RIN;
						rmiss_d  = '0;
						rfound_d = '0;
						mark_d   = item.odometer;
					end
				end
			end
			PH_RIN: begin
				fr = 1'b1;
				if (pts_lt(item.right_points, cfg.inside_lost) || arc_done)
					phase_d = PH_RRUN;
			end
			PH_RRUN: begin
				if (item.left_corner_found) begin
					tl   = 1'b1;
					tlen = TRIM_BITS'(item.left_corner_index);
					if (pts_lt(item.left_corner_index, cfg.exit_corner))
						phase_d = PH_ROUT;
				end
			end
			PH_ROUT: begin
				fr = 1'b1;
				if (item.left_straight)
					phase_d = PH_REND;
			end
			PH_REND: begin
				rmiss_d = rmiss_inc;
				if (pts_gt(item.right_points, cfg.found_line) && rmiss_inc > REND_MISS_MIN) begin
					phase_d = PH_NONE;
					rmiss_d = '0;
				end
			end
			PH_NONE: fv = 1'b0;
			default: fv = 1'b0;
		endcase
	end

	// State registers advance once per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NONE;
			lmiss_q  <= '0;
			lfound_q <= '0;
			rmiss_q  <= '0;
			rfound_q <= '0;
			mark_q   <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			lmiss_q  <= lmiss_d;
			lfound_q <= lfound_d;
			rmiss_q  <= rmiss_d;
			rfound_q <= rfound_d;
			mark_q   <= mark_d;
		end
	end

	// Result of this frame
	always_comb begin
		res.ring_state   = phase_code(phase_d);
		res.follow_right = fr;
		res.follow_valid = fv;
		res.trim_left    = tl;
		res.trim_right   = tr;
		res.trim_length  = tlen;
	end

endmodule

`default_nettype wire

### hw/rtl/roundabout_track_sequencer.sv
// Top level of the roundabout track sequencer: beat registers, handshakes, submodules.
// Usage:
//   Input channel (in_valid/in_ready) carries one camera frame's boundary summary per
//   beat; output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat, in order: the ring state, the boundary to follow and an optional trim.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
//   thresholds; cfg_ready is always high. Write config only while the block is idle.
// Timing:
//   A frame beat is captured in the input register, stepped through the phase logic
//   and lands in the result register once that register is empty or its beat is taken.
//   One beat per cycle is sustained while out_ready stays high; the phase update from
//   input register to result register is combinational.
// Reset:
//   arst_n clears the valid flags of both beat registers, the phase (back to no roundabout),
//   all miss and found counters, the entry mark, and loads the default thresholds.
// Stall:
//   With out_ready low the result holds; the input register still takes one more beat,
//   then in_ready drops until the result is taken.
`default_nettype none

module roundabout_track_sequencer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// frame input
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    left_corner_found,
	input  logic                                    right_corner_found,
	input  logic                                    left_straight,
	input  logic                                    right_straight,
	input  logic [rts_pkg::POINT_BITS-1:0]          left_points,
	input  logic [rts_pkg::POINT_BITS-1:0]          right_points,
	input  logic [rts_pkg::POINT_BITS-1:0]          left_corner_index,
	input  logic [rts_pkg::POINT_BITS-1:0]          right_corner_index,
	input  logic signed [rts_pkg::ODO_BITS-1:0]     odometer,
	// result output
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [rts_pkg::CODE_BITS-1:0]           ring_state,
	output logic                                    follow_right,
	output logic                                    follow_valid,
	output logic                                    trim_left,
	output logic                                    trim_right,
	output logic [rts_pkg::TRIM_BITS-1:0]           trim_length,
	// configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rts_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [rts_pkg::CFG_DAT_BITS-1:0]        cfg_data
);
	import rts_pkg::*;

	rts_item_t   item_s1;
	logic        valid_s1;
	rts_result_t res_s2;
	logic        valid_s2;
	rts_result_t res_d;
	rts_cfg_t    cfg;
	logic        advance;
	logic        in_fire;

	// Handshakes
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.left_corner_found  <= left_corner_found;
			item_s1.right_corner_found <= right_corner_found;
			item_s1.left_straight      <= left_straight;
			item_s1.right_straight     <= right_straight;
			item_s1.left_points        <= left_points;
			item_s1.right_points       <= right_points;
			item_s1.left_corner_index  <= left_corner_index;
			item_s1.right_corner_index <= right_corner_index;
			item_s1.odometer           <= $unsigned(odometer);
		end
	end

	rts_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rts_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_d)
	);

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_d;
	end

	assign out_valid    = valid_s2;
	assign ring_state   = res_s2.ring_state;
	assign follow_right = res_s2.follow_right;
	assign follow_valid = res_s2.follow_valid;
	assign trim_left    = res_s2.trim_left;
	assign trim_right   = res_s2.trim_right;
	assign trim_length  = res_s2.trim_length;

endmodule

`default_nettype wire

### hw/rtl/rts_checker.sv
// Port-level checker for the roundabout track sequencer, bound to the top level.
`default_nettype none

`include "roundabout_track_sequencer_assert.svh"

module rts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [rts_pkg::CODE_BITS-1:0]   ring_state,
	input logic                            follow_valid,
	input logic                            trim_left,
	input logic                            trim_right,
	input logic [rts_pkg::TRIM_BITS-1:0]   trim_length
);
	import rts_pkg::*;

	// Any state but none commands a follow side; the end frame may report none while commanded
	`RTS_ASSERT_ON_OUT(a_follow_vs_state, ring_state == CODE_NONE || follow_valid, "follow_valid low outside none")

	// Right trim only comes from the left-ring run phase, left trim from the right one
	`RTS_ASSERT_ON_OUT(a_trim_phase, (!trim_right || ring_state == CODE_LRUN || ring_state == CODE_LOUT) && (!trim_left || ring_state == CODE_RRUN || ring_state == CODE_ROUT), "trim in wrong phase")

	// No trim means a zero length
	`RTS_ASSERT_ON_OUT(a_trim_len, trim_left || trim_right || trim_length == '0, "trim_length set without trim")

	// A stalled result beat holds
	`RTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(ring_state) && $stable(trim_length), "result beat changed while stalled")

endmodule

bind roundabout_track_sequencer rts_checker u_rts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.ring_state   (ring_state),
	.follow_valid (follow_valid),
	.trim_left    (trim_left),
	.trim_right   (trim_right),
	.trim_length  (trim_length)
);

`default_nettype wire
